FILE: design/ect_pkg.sv
// Shared types and codes of the edge contour tracer.
`timescale 1ns / 1ps
package ect_pkg;

	// Input commands.
	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_START   = 2'd1,
		CMD_ADVANCE = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STS_WRITTEN = 3'd0,
		STS_START   = 3'd1,
		STS_NEXT    = 3'd2,
		STS_CLOSED  = 3'd3,
		STS_NONE    = 3'd4,
		STS_FULL    = 3'd5,
		STS_IDLE    = 3'd6
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_SEARCH_RADIUS = 2'd0,
		REG_CLOSE_RADIUS  = 2'd1,
		REG_IMAGE_COLS    = 2'd2,
		REG_IMAGE_ROWS    = 2'd3
	} reg_idx_t;

	// Control bits of a candidate moving down the cell chain.
	typedef struct packed {
		logic valid;
		logic last;
		logic ok;
		logic hit;
	} tok_ctl_t;

	// Reset values of the registers.
	localparam logic [2:0] RADIUS_RESET = 3'd5;
	localparam logic [7:0] CLOSE_RESET = 8'd10;
	localparam logic [6:0] COLS_RESET = 7'd64;
	localparam logic [6:0] ROWS_RESET = 7'd64;

	// A path must hold more than this many points before it can close.
	localparam int CLOSE_MIN_POINTS = 10;

endpackage

FILE: design/ect_cell.sv
// One path store cell: holds a path point and checks passing candidates.
`timescale 1ns / 1ps
module ect_cell #(
	parameter int K = 0,
	parameter int CW = 6,
	parameter int IW = 8,
	parameter int PW = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              kill,
	input  logic [PW-1:0]     count,
	input  logic              wr_en,
	input  logic [IW-1:0]     wr_idx,
	input  logic [CW-1:0]     wr_x,
	input  logic [CW-1:0]     wr_y,
	input  ect_pkg::tok_ctl_t in_ctl,
	input  logic [CW-1:0]     in_x,
	input  logic [CW-1:0]     in_y,
	output ect_pkg::tok_ctl_t out_ctl,
	output logic [CW-1:0]     out_x,
	output logic [CW-1:0]     out_y
);
	import ect_pkg::*;

	localparam logic [IW-1:0] KI = IW'(K);
	localparam logic [PW-1:0] KP = PW'(K);

	logic [CW-1:0] pt_x_q, pt_y_q;
	tok_ctl_t      ctl_q;
	logic [CW-1:0] x_q, y_q;
	logic [CW:0]   ax, bx, ay, by;
	logic          near, used;

	// Stored point is written once per append.
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == KI) begin
			pt_x_q <= wr_x;
			pt_y_q <= wr_y;
		end
	end

	// The point counts only while it lies inside the current path.
	assign used = KP < count;

	// Chebyshev distance of at most one on both axes.
	always_comb begin
		ax = {1'b0, pt_x_q};
		bx = {1'b0, in_x};
		ay = {1'b0, pt_y_q};
		by = {1'b0, in_y};
		near = (ax == bx || ax == bx + 1'b1 || ax + 1'b1 == bx) &&
		       (ay == by || ay == by + 1'b1 || ay + 1'b1 == by);
	end

	// Candidate register hands the token to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (kill) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= '{valid: in_ctl.valid, last: in_ctl.last, ok: in_ctl.ok,
			           hit: in_ctl.hit | (in_ctl.valid & used & near)};
		end
	end

	always_ff @(posedge clk) begin
		x_q <= in_x;
		y_q <= in_y;
	end

	assign out_ctl = ctl_q;
	assign out_x = x_q;
	assign out_y = y_q;

endmodule

FILE: design/edge_contour_tracer.sv
// Top level of the edge contour tracer: command decode, window scan and path chain.
`timescale 1ns / 1ps
// Usage:
// An item is taken at a clock edge with start high and busy low. A write
// (cmd 0) loads one edge map pixel, a start (cmd 1) opens a new path, an
// advance (cmd 2) looks for the next contour point. Every item gives one
// result on point_x, point_y, status and path_length, marked by done for
// one cycle; the receiver cannot stall and takes it in that cycle.
// Writes, starts and refused advances answer in the next cycle and busy
// stays low, so such items can follow in every cycle.
// An advance streams the window positions, one per cycle, through the edge
// map read port and then down a chain of MAX_POINTS cells, one cell per
// cycle, each holding one path point. The window holds (2*search_radius+1)^2
// positions; the result comes from the first free edge pixel among them,
// and busy is high until it appears.
// Reset clears the path count, trace state and registers to their defaults;
// the edge map and path points hold nothing defined until written.
// Registers on the APB port: search_radius at 0x0, close_radius at 0x4,
// image_cols at 0x8, image_rows at 0xC; write them only while idle.
module edge_contour_tracer #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64,
	parameter int MAX_POINTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [5:0]  pos_x,
	input  logic [5:0]  pos_y,
	input  logic [7:0]  pixel_value,
	output logic        done,
	output logic [5:0]  point_x,
	output logic [5:0]  point_y,
	output logic [2:0]  status,
	output logic [8:0]  path_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ect_pkg::*;

	localparam int AXW = $clog2(MAX_COLS);
	localparam int AYW = $clog2(MAX_ROWS);
	localparam int AMX = (AXW > AYW) ? AXW : AYW;
	localparam int CW = (AMX > 6) ? AMX : 6;
	localparam int SW = CW + 2;
	localparam int IW = $clog2(MAX_POINTS);
	localparam int PW = $clog2(MAX_POINTS + 1);
	localparam int DW = 2 * CW + 4;
	localparam int CLIM = (MAX_COLS > 127) ? 127 : MAX_COLS;
	localparam int RLIM = (MAX_ROWS > 127) ? 127 : MAX_ROWS;

	// Configuration registers.
	logic [2:0] radius_q;
	logic [7:0] close_q;
	logic [6:0] cols_q, rows_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			close_q  <= CLOSE_RESET;
			cols_q   <= COLS_RESET;
			rows_q   <= ROWS_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_SEARCH_RADIUS: radius_q <= pwdata[2:0];
				REG_CLOSE_RADIUS:  close_q  <= pwdata[7:0];
				REG_IMAGE_COLS:    cols_q   <= pwdata[6:0];
				REG_IMAGE_ROWS:    rows_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_SEARCH_RADIUS: prdata = {29'd0, radius_q};
			REG_CLOSE_RADIUS:  prdata = {24'd0, close_q};
			REG_IMAGE_COLS:    prdata = {25'd0, cols_q};
			REG_IMAGE_ROWS:    prdata = {25'd0, rows_q};
			default:           prdata = '0;
		endcase
	end

	// Trace state.
	state_t        state_q, state_d;
	logic [PW-1:0] count_q;
	logic [CW-1:0] cur_x_q, cur_y_q, st_x_q, st_y_q;
	logic          active_q;
	logic          accept;
	cmd_t          cmd_in;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign cmd_in = cmd_t'(cmd);

	// Window scan counters and candidate generation.
	logic signed [3:0]    dx_q, dy_q, rad_s;
	logic signed [SW-1:0] sx, sy, cols_s, rows_s;
	logic [6:0]           cols_eff, rows_eff;
	logic                 issue, issue_last, in_img;

	assign rad_s = $signed({1'b0, radius_q});
	assign cols_eff = (cols_q > 7'(CLIM)) ? 7'(CLIM) : cols_q;
	assign rows_eff = (rows_q > 7'(RLIM)) ? 7'(RLIM) : rows_q;
	assign cols_s = $signed(SW'(cols_eff));
	assign rows_s = $signed(SW'(rows_eff));
	assign issue = (state_q == ST_SCAN);
	assign issue_last = (dx_q == rad_s) && (dy_q == rad_s);

	always_comb begin
		sx = $signed(SW'(cur_x_q)) + SW'(dx_q);
		sy = $signed(SW'(cur_y_q)) + SW'(dy_q);
		in_img = (sx >= 0) && (sx < cols_s) && (sy >= 0) && (sy < rows_s) &&
		         !(dx_q == 0 && dy_q == 0);
	end

	// Edge map with one write and one registered read port.
	logic                 edge_mem [2**(AXW+AYW)];
	logic                 edge_rd_q;
	logic [AXW+AYW-1:0]   rd_addr;
	logic                 pix_wr;

	assign rd_addr = {sy[AYW-1:0], sx[AXW-1:0]};
	assign pix_wr = accept && cmd_in == CMD_WRITE &&
	                int'(pos_x) < MAX_COLS && int'(pos_y) < MAX_ROWS;

	always_ff @(posedge clk) begin
		if (pix_wr)
			edge_mem[{AYW'(pos_y), AXW'(pos_x)}] <= |pixel_value;
		edge_rd_q <= edge_mem[rd_addr];
	end

	// Candidate stage one, aligned with the edge map read.
	tok_ctl_t      ctl_s1;
	logic [CW-1:0] x_s1, y_s1;
	logic          kill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (kill) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= '{valid: issue, last: issue_last, ok: in_img, hit: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= sx[CW-1:0];
		y_s1 <= sy[CW-1:0];
	end

	// Chain of path cells.
	tok_ctl_t      ctl_c [MAX_POINTS+1];
	logic [CW-1:0] x_c [MAX_POINTS+1];
	logic [CW-1:0] y_c [MAX_POINTS+1];
	logic          pt_wr;
	logic [IW-1:0] pt_idx;
	logic [CW-1:0] pt_x, pt_y;

	assign ctl_c[0] = '{valid: ctl_s1.valid, last: ctl_s1.last,
	                    ok: ctl_s1.ok & edge_rd_q, hit: ctl_s1.hit};
	assign x_c[0] = x_s1;
	assign y_c[0] = y_s1;

	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
		ect_cell #(.K(k), .CW(CW), .IW(IW), .PW(PW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.kill    (kill),
			.count   (count_q),
			.wr_en   (pt_wr),
			.wr_idx  (pt_idx),
			.wr_x    (pt_x),
			.wr_y    (pt_y),
			.in_ctl  (ctl_c[k]),
			.in_x    (x_c[k]),
			.in_y    (y_c[k]),
			.out_ctl (ctl_c[k+1]),
			.out_x   (x_c[k+1]),
			.out_y   (y_c[k+1])
		);
	end

	// End of chain: first free edge pixel wins, a last token ends the search.
	tok_ctl_t      ctl_end;
	logic          win, fin;
	logic [CW-1:0] win_x, win_y;

	assign ctl_end = ctl_c[MAX_POINTS];
	assign win_x = x_c[MAX_POINTS];
	assign win_y = y_c[MAX_POINTS];
	assign win = ctl_end.valid && ctl_end.ok && !ctl_end.hit;
	assign fin = (state_q != ST_IDLE) && ctl_end.valid && (win || ctl_end.last);
	assign kill = fin;

	// Closure distance to the start point.
	logic signed [DW-1:0] ex, ey;
	logic [DW-1:0]        d2, c2;
	logic                 closes;

	always_comb begin
		ex = $signed(DW'(win_x)) - $signed(DW'(st_x_q));
		ey = $signed(DW'(win_y)) - $signed(DW'(st_y_q));
		d2 = DW'($unsigned(ex * ex)) + DW'($unsigned(ey * ey));
		c2 = DW'(close_q) * DW'(close_q);
		closes = (int'(count_q) + 1 > CLOSE_MIN_POINTS) && (d2 < c2);
	end

	// Path point writes: the start point or a winning candidate.
	always_comb begin
		pt_wr = 1'b0;
		pt_idx = count_q[IW-1:0];
		pt_x = win_x;
		pt_y = win_y;
		if (accept && cmd_in == CMD_START) begin
			pt_wr = 1'b1;
			pt_idx = '0;
			pt_x = CW'(pos_x);
			pt_y = CW'(pos_y);
		end else if (fin && win) begin
			pt_wr = 1'b1;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd_in == CMD_ADVANCE && active_q &&
				    int'(count_q) < MAX_POINTS)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (fin)
					state_d = ST_IDLE;
				else if (issue_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (fin)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Scan counters step y inside x.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			dx_q <= -rad_s;
			dy_q <= -rad_s;
		end else if (issue && !issue_last) begin
			if (dy_q == rad_s) begin
				dy_q <= -rad_s;
				dx_q <= dx_q + 4'sd1;
			end else begin
				dy_q <= dy_q + 4'sd1;
			end
		end
	end

	// Trace state and result registers.
	logic [CW-1:0] res_x_q, res_y_q;
	status_t       res_st_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			st_x_q   <= '0;
			st_y_q   <= '0;
			active_q <= 1'b0;
			done_q   <= 1'b0;
			res_x_q  <= '0;
			res_y_q  <= '0;
			res_st_q <= STS_WRITTEN;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				unique case (cmd_in)
					CMD_WRITE: begin
						done_q   <= 1'b1;
						res_x_q  <= CW'(pos_x);
						res_y_q  <= CW'(pos_y);
						res_st_q <= STS_WRITTEN;
					end
					CMD_START: begin
						done_q   <= 1'b1;
						cur_x_q  <= CW'(pos_x);
						cur_y_q  <= CW'(pos_y);
						st_x_q   <= CW'(pos_x);
						st_y_q   <= CW'(pos_y);
						count_q  <= PW'(1);
						active_q <= 1'b1;
						res_x_q  <= CW'(pos_x);
						res_y_q  <= CW'(pos_y);
						res_st_q <= STS_START;
					end
					default: begin
						if (cmd_in != CMD_ADVANCE || !active_q) begin
							done_q   <= 1'b1;
							res_x_q  <= cur_x_q;
							res_y_q  <= cur_y_q;
							res_st_q <= STS_IDLE;
						end else if (int'(count_q) >= MAX_POINTS) begin
							done_q   <= 1'b1;
							active_q <= 1'b0;
							res_x_q  <= cur_x_q;
							res_y_q  <= cur_y_q;
							res_st_q <= STS_FULL;
						end
					end
				endcase
			end else if (fin) begin
				done_q <= 1'b1;
				if (win) begin
					cur_x_q  <= win_x;
					cur_y_q  <= win_y;
					count_q  <= count_q + 1'b1;
					res_x_q  <= win_x;
					res_y_q  <= win_y;
					res_st_q <= closes ? STS_CLOSED : STS_NEXT;
					if (closes)
						active_q <= 1'b0;
				end else begin
					active_q <= 1'b0;
					res_x_q  <= cur_x_q;
					res_y_q  <= cur_y_q;
					res_st_q <= STS_NONE;
				end
			end
		end
	end

	assign done = done_q;
	assign point_x = res_x_q[5:0];
	assign point_y = res_y_q[5:0];
	assign status = res_st_q;
	assign path_length = 9'(count_q);

endmodule

FILE: design/ect_checker.sv
// Port level checks of the edge contour tracer, bound to the top level.
`timescale 1ns / 1ps
module ect_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] cmd,
	input logic [5:0] pos_x,
	input logic       done,
	input logic [5:0] point_x,
	input logic [2:0] status,
	input logic [8:0] path_length
);
	import ect_pkg::*;

	// A write or start is answered in the next cycle.
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == CMD_WRITE || cmd == CMD_START) |=> done)
		else $error("write or start not answered in the next cycle");

	// A write result echoes the column that was written.
	a_write_echo: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STS_WRITTEN |-> point_x == $past(pos_x))
		else $error("write result does not echo the column");

	// A start result reports a path of one point.
	a_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STS_START |-> path_length == 9'd1)
		else $error("start result with wrong path length");

	// A step to a new point lengthens the path.
	a_next_grows: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STS_NEXT || status == STS_CLOSED) |->
		path_length > 9'd1)
		else $error("new point without a longer path");

	// Status codes stay within the defined set.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 3'd7)
		else $error("undefined status code");

endmodule

bind edge_contour_tracer ect_checker u_ect_checker (.*);
